>>> src/hexapod_foot_target_generator_core_defines.svh
// ============================================================================
// Assertion macros for the hexapod foot target generator
// Clocked on aclk, disabled while aresetn is low. Empty when SYNTH is defined.
// ============================================================================
`ifndef HEXAPOD_FOOT_TARGET_GENERATOR_CORE_DEFINES_SVH
`define HEXAPOD_FOOT_TARGET_GENERATOR_CORE_DEFINES_SVH

`ifndef SYNTH
`define HFTG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);
`define HFTG_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (pre) |=> (post)) else $error(msg);
`else
`define HFTG_ASSERT(label, prop, msg)
`define HFTG_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

>>> src/hftg_pkg.sv
// ============================================================================
// hftg_pkg
// Payload types, register indexes and fixed-point helpers of the foot target
// generator.
// ============================================================================
package hftg_pkg;

    localparam int LEG_COUNT = 6;
    localparam logic [2:0] LEG_FIRST = 3'd0;
    localparam logic [2:0] LEG_LAST  = 3'(LEG_COUNT - 1);

    // cos(30 deg) in Q1.14
    localparam logic signed [15:0] COS30_Q14 = 16'sd14189;

    localparam logic signed [15:0] IDLE_X_RST  = 16'sd1600;
    localparam logic signed [15:0] IDLE_Y_RST  = 16'sd0;
    localparam logic signed [15:0] IDLE_Z_RST  = -16'sd1600;
    localparam logic [11:0]        RADIUS_RST  = 12'd1280;
    localparam logic [9:0]         STEP_H_RST  = 10'd320;
    localparam logic [15:0]        STANCE_RST  = 16'd2048;

    localparam int CFG_DATA_W = 16;

    typedef enum logic [2:0] {
        CFG_IDLE_FOOT_X    = 3'd0,
        CFG_IDLE_FOOT_Y    = 3'd1,
        CFG_IDLE_FOOT_Z    = 3'd2,
        CFG_CHASSIS_RADIUS = 3'd3,
        CFG_STEP_HEIGHT    = 3'd4,
        CFG_STANCE_TIME    = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] yaw_rate;
    } in_t;

    typedef struct packed {
        logic [2:0]         leg_index;
        logic               last_leg;
        logic signed [15:0] stance_x;
        logic signed [15:0] stance_y;
        logic signed [15:0] swing_x;
        logic signed [15:0] swing_y;
        logic signed [15:0] rest_x;
        logic signed [15:0] rest_y;
        logic signed [15:0] ground_z;
        logic signed [15:0] lift_z;
    } out_t;

    localparam int SAT_IN_W = 52;

    function automatic logic signed [15:0] sat16(input logic signed [SAT_IN_W-1:0] v);
        logic signed [15:0] r;
        if (v > 52'sd32767) begin
            r = 16'sd32767;
        end else if (v < -52'sd32768) begin
            r = -16'sd32768;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

>>> src/hexapod_foot_target_generator_core.sv
// ============================================================================
// hexapod_foot_target_generator_core
// Tripod-gait foot placement: one velocity command in, six leg targets out.
// ============================================================================
// Usage:
//   s_valid/s_ready/s_data carry one velocity command (vel_x, vel_y, yaw_rate).
//   Each command produces six transactions on m_valid/m_ready/m_data, legs 0..5
//   in order, last_leg set on leg 5.
//   cfg_we/cfg_index/cfg_wdata write the six geometry/timing registers; only
//   write while the block is idle. Indexes 6 and 7 are ignored.
// Pipeline:
//   A command sequencer feeds one leg per cycle, unless the output stalls,
//   into a seven-register pipeline. The next command is taken as leg 5
//   issues, so with no stall the pipeline carries one result per cycle.
// Reset and stalls:
//   aresetn (sync, active low) empties the pipeline and loads register
//   defaults. While a result waits on m_ready the whole pipeline and the
//   sequencer hold; nothing is dropped or repeated.
// ============================================================================
`include "hexapod_foot_target_generator_core_defines.svh"

module hexapod_foot_target_generator_core
    import hftg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [15:0] idle_x_reg, idle_y_reg, idle_z_reg;
    logic [11:0]        radius_reg;
    logic [9:0]         step_h_reg;
    logic [15:0]        stance_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_x_reg <= IDLE_X_RST;
            idle_y_reg <= IDLE_Y_RST;
            idle_z_reg <= IDLE_Z_RST;
            radius_reg <= RADIUS_RST;
            step_h_reg <= STEP_H_RST;
            stance_reg <= STANCE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_IDLE_FOOT_X:    idle_x_reg <= cfg_wdata[15:0];
                CFG_IDLE_FOOT_Y:    idle_y_reg <= cfg_wdata[15:0];
                CFG_IDLE_FOOT_Z:    idle_z_reg <= cfg_wdata[15:0];
                CFG_CHASSIS_RADIUS: radius_reg <= cfg_wdata[11:0];
                CFG_STEP_HEIGHT:    step_h_reg <= cfg_wdata[9:0];
                CFG_STANCE_TIME:    stance_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // leg-frame foot point pushed out by the chassis radius
    logic signed [16:0] foot_x;
    logic signed [15:0] foot_y;
    assign foot_x = $signed({idle_x_reg[15], idle_x_reg}) + $signed({5'b0, radius_reg});
    assign foot_y = idle_y_reg;

    // ------------------------------------------------------------------
    // Command sequencer
    // ------------------------------------------------------------------
    logic       pipe_en;
    logic       issue;
    logic       busy_reg;
    logic [2:0] leg_reg;
    in_t        cmd_reg;
    logic [2:0] leg_next;

    assign pipe_en  = !m_valid || m_ready;
    assign issue    = busy_reg && pipe_en;
    assign s_ready  = !busy_reg || (issue && leg_reg == LEG_LAST);
    assign leg_next = leg_reg + 3'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            leg_reg  <= LEG_FIRST;
        end else if (s_valid && s_ready) begin
            busy_reg <= 1'b1;
            leg_reg  <= LEG_FIRST;
        end else if (issue) begin
            if (leg_reg == LEG_LAST) begin
                busy_reg <= 1'b0;
            end else begin
                leg_reg <= leg_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= s_data;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline valid bits
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s4_valid_reg, s5_valid_reg, s6_valid_reg, m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (pipe_en) begin
            s1_valid_reg <= busy_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            m_valid_reg  <= s6_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

    // ------------------------------------------------------------------
    // Stage 1: cos products
    // ------------------------------------------------------------------
    logic [2:0]         s1_leg_reg;
    in_t                s1_cmd_reg;
    logic signed [32:0] s1_pcx_reg, s1_pcy_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s1_leg_reg <= leg_reg;
            s1_cmd_reg <= cmd_reg;
            s1_pcx_reg <= 33'(foot_x) * 33'(COS30_Q14);
            s1_pcy_reg <= 33'(foot_y) * 33'(COS30_Q14);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: rest point (rotation by 30 + 60*leg degrees)
    // ------------------------------------------------------------------
    logic signed [33:0] fx_w, fy_w, pcx_w, pcy_w;
    logic signed [33:0] cx, cy, sfx, sfy;
    logic signed [33:0] rx_sum, ry_sum;
    logic signed [33:0] rx_rnd, ry_rnd;

    always_comb begin
        fx_w  = 34'(foot_x);
        fy_w  = 34'(foot_y);
        pcx_w = 34'(s1_pcx_reg);
        pcy_w = 34'(s1_pcy_reg);
        case (s1_leg_reg)
            3'd0: begin
                cx = pcx_w;   cy = pcy_w;
                sfx = fx_w <<< 13;     sfy = fy_w <<< 13;
            end
            3'd1: begin
                cx = '0;      cy = '0;
                sfx = fx_w <<< 14;     sfy = fy_w <<< 14;
            end
            3'd2: begin
                cx = -pcx_w;  cy = -pcy_w;
                sfx = fx_w <<< 13;     sfy = fy_w <<< 13;
            end
            3'd3: begin
                cx = -pcx_w;  cy = -pcy_w;
                sfx = -(fx_w <<< 13);  sfy = -(fy_w <<< 13);
            end
            3'd4: begin
                cx = '0;      cy = '0;
                sfx = -(fx_w <<< 14);  sfy = -(fy_w <<< 14);
            end
            3'd5: begin
                cx = pcx_w;   cy = pcy_w;
                sfx = -(fx_w <<< 13);  sfy = -(fy_w <<< 13);
            end
            default: begin
                cx = '0;  cy = '0;  sfx = '0;  sfy = '0;
            end
        endcase
        rx_sum = cx - sfy;
        ry_sum = cy + sfx;
        rx_rnd = (rx_sum + 34'sd8192) >>> 14;
        ry_rnd = (ry_sum + 34'sd8192) >>> 14;
    end

    logic [2:0]         s2_leg_reg;
    in_t                s2_cmd_reg;
    logic signed [15:0] s2_rx_reg, s2_ry_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s2_leg_reg <= s1_leg_reg;
            s2_cmd_reg <= s1_cmd_reg;
            s2_rx_reg  <= sat16(52'(rx_rnd));
            s2_ry_reg  <= sat16(52'(ry_rnd));
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: yaw cross products
    // ------------------------------------------------------------------
    logic [2:0]         s3_leg_reg;
    logic signed [15:0] s3_vx_reg, s3_vy_reg, s3_rx_reg, s3_ry_reg;
    logic signed [31:0] s3_wry_reg, s3_wrx_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s3_leg_reg <= s2_leg_reg;
            s3_vx_reg  <= s2_cmd_reg.vel_x;
            s3_vy_reg  <= s2_cmd_reg.vel_y;
            s3_rx_reg  <= s2_rx_reg;
            s3_ry_reg  <= s2_ry_reg;
            s3_wry_reg <= 32'(s2_cmd_reg.yaw_rate) * 32'(s2_ry_reg);
            s3_wrx_reg <= 32'(s2_cmd_reg.yaw_rate) * 32'(s2_rx_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: foot velocity, 2^-12 units
    // ------------------------------------------------------------------
    logic [2:0]         s4_leg_reg;
    logic signed [15:0] s4_rx_reg, s4_ry_reg;
    logic signed [32:0] s4_fqx_reg, s4_fqy_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s4_leg_reg <= s3_leg_reg;
            s4_rx_reg  <= s3_rx_reg;
            s4_ry_reg  <= s3_ry_reg;
            s4_fqx_reg <= 33'(s3_wry_reg) - 33'($signed({s3_vx_reg, 12'b0}));
            s4_fqy_reg <= -(33'($signed({s3_vy_reg, 12'b0})) + 33'(s3_wrx_reg));
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: displacement partial products (stance_time split in bytes)
    // ------------------------------------------------------------------
    logic signed [8:0]  t_lo, t_hi;
    assign t_lo = $signed({1'b0, stance_reg[7:0]});
    assign t_hi = $signed({1'b0, stance_reg[15:8]});

    logic [2:0]         s5_leg_reg;
    logic signed [15:0] s5_rx_reg, s5_ry_reg;
    logic signed [41:0] s5_xlo_reg, s5_xhi_reg, s5_ylo_reg, s5_yhi_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s5_leg_reg <= s4_leg_reg;
            s5_rx_reg  <= s4_rx_reg;
            s5_ry_reg  <= s4_ry_reg;
            s5_xlo_reg <= 42'(s4_fqx_reg) * 42'(t_lo);
            s5_xhi_reg <= 42'(s4_fqx_reg) * 42'(t_hi);
            s5_ylo_reg <= 42'(s4_fqy_reg) * 42'(t_lo);
            s5_yhi_reg <= 42'(s4_fqy_reg) * 42'(t_hi);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: half displacement, round half up at 2^-25
    // ------------------------------------------------------------------
    localparam logic signed [51:0] HALF_ULP = 52'sd16777216;

    logic signed [51:0] hx_sum, hy_sum;
    assign hx_sum = (52'(s5_xhi_reg) <<< 8) + 52'(s5_xlo_reg) + HALF_ULP;
    assign hy_sum = (52'(s5_yhi_reg) <<< 8) + 52'(s5_ylo_reg) + HALF_ULP;

    logic [2:0]         s6_leg_reg;
    logic signed [15:0] s6_rx_reg, s6_ry_reg;
    logic signed [25:0] s6_hx_reg, s6_hy_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s6_leg_reg <= s5_leg_reg;
            s6_rx_reg  <= s5_rx_reg;
            s6_ry_reg  <= s5_ry_reg;
            s6_hx_reg  <= hx_sum[50:25];
            s6_hy_reg  <= hy_sum[50:25];
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: output register
    // ------------------------------------------------------------------
    logic signed [26:0] rx_w, ry_w, hx_w, hy_w;
    logic signed [17:0] lift_sum;
    out_t               m_data_reg;
    out_t               m_data_next;

    assign rx_w     = 27'(s6_rx_reg);
    assign ry_w     = 27'(s6_ry_reg);
    assign hx_w     = 27'(s6_hx_reg);
    assign hy_w     = 27'(s6_hy_reg);
    assign lift_sum = 18'(idle_z_reg) + $signed({8'b0, step_h_reg});

    always_comb begin
        m_data_next.leg_index = s6_leg_reg;
        m_data_next.last_leg  = (s6_leg_reg == LEG_LAST);
        m_data_next.stance_x  = sat16(52'(rx_w + hx_w));
        m_data_next.stance_y  = sat16(52'(ry_w + hy_w));
        m_data_next.swing_x   = sat16(52'(rx_w - hx_w));
        m_data_next.swing_y   = sat16(52'(ry_w - hy_w));
        m_data_next.rest_x    = s6_rx_reg;
        m_data_next.rest_y    = s6_ry_reg;
        m_data_next.ground_z  = idle_z_reg;
        m_data_next.lift_z    = sat16(52'(lift_sum));
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_data = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `HFTG_ASSERT(a_accept_only_at_last_leg,
        (s_valid && s_ready && busy_reg) |-> (issue && leg_reg == LEG_LAST),
        "command taken mid-sequence")
    `HFTG_ASSERT_NEXT(a_stall_holds_valids, !pipe_en,
        $stable({s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg,
                 s5_valid_reg, s6_valid_reg, m_valid_reg}),
        "pipeline moved during stall")
    `HFTG_ASSERT_NEXT(a_issue_enters_pipe, issue,
        s1_valid_reg && s1_leg_reg == $past(leg_reg),
        "issued leg not captured")
    `HFTG_ASSERT(a_last_leg_code,
        m_valid |-> (m_data.last_leg == (m_data.leg_index == LEG_LAST)),
        "last_leg mismatch")

endmodule
